[src/nca_pkg.sv]
`timescale 1ns / 1ps
// shared constants, types and codes for the nearest center assignment block
// no dependencies

package nca_pkg;

    localparam int MAX_CENTERS = 8;
    localparam int MAX_DIMS    = 16;

    localparam int CIDX_W = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int DIDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CNT_W  = $clog2(MAX_CENTERS + 1);

    localparam int COORD_W    = 16;
    localparam int DIM_W      = 4;
    localparam int SEL_W      = 3;
    localparam int NEAR_W     = 3;
    localparam int DIST_W     = 36;
    localparam int SQ_W       = 32;
    localparam int ACTC_W     = 4;
    localparam int ACTD_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef enum logic [0:0] {
        OP_CENTER = 1'b0,
        OP_POINT  = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_CENTERS = 1'b0,
        REG_ACTIVE_DIMS    = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic                      en;
        logic [SEL_W-1:0]          sel;
        logic [DIM_W-1:0]          dim;
        logic signed [COORD_W-1:0] value;
    } center_wr_t;

    typedef struct packed {
        logic                      valid;
        logic                      last;
        logic [DIM_W-1:0]          dim;
        logic signed [COORD_W-1:0] value;
        logic [CNT_W-1:0]          remain;
        logic [CIDX_W-1:0]         pos;
        logic [CIDX_W-1:0]         best_idx;
        logic [DIST_W-1:0]         best_dist;
    } token_t;

endpackage

[src/nca_if.sv]
`timescale 1ns / 1ps
// valid/ready channel interfaces for point and center transactions and results
// depends on nca_pkg

interface nca_req_if;
    import nca_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      op;
    logic [SEL_W-1:0]          center_sel;
    logic [DIM_W-1:0]          dim_index;
    logic signed [COORD_W-1:0] coord_value;

    modport source (output valid, op, center_sel, dim_index, coord_value, input ready);
    modport sink   (input valid, op, center_sel, dim_index, coord_value, output ready);
endinterface

interface nca_rsp_if;
    import nca_pkg::*;
    logic                valid;
    logic                ready;
    logic [NEAR_W-1:0]   nearest;
    logic [DIST_W-1:0]   nearest_distance;

    modport source (output valid, nearest, nearest_distance, input ready);
    modport sink   (input valid, nearest, nearest_distance, output ready);
endinterface

[src/nca_cell.sv]
`timescale 1ns / 1ps
// one center of the chain: coordinates, squared difference, running sum, best compare
// depends on nca_pkg

module nca_cell
    import nca_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CIDX_W-1:0] cell_id,
    input  center_wr_t        wr,
    input  token_t            tok_in,
    output token_t            tok_out
);

    logic signed [COORD_W-1:0] coord_reg [MAX_DIMS];
    token_t                    a_tok_reg;
    token_t                    b_tok_reg;
    logic [SQ_W-1:0]           sq_reg;
    logic [DIST_W-1:0]         sum_reg;

    logic signed [COORD_W-1:0] cur_coord;
    logic [COORD_W:0]          diff;
    logic [COORD_W:0]          diff_neg;
    logic [COORD_W-1:0]        mag;
    logic [SQ_W-1:0]           sq_next;
    logic                      wr_hit;
    logic [DIST_W:0]           sum_wide;
    logic [DIST_W-1:0]         sum_sat;
    logic                      active;
    logic                      take;
    token_t                    tok_next;

    // stage a: squared difference against this center
    always_comb
    begin
        cur_coord = coord_reg[tok_in.dim[DIDX_W-1:0]];
        diff      = {tok_in.value[COORD_W-1], tok_in.value} - {cur_coord[COORD_W-1], cur_coord};
        diff_neg  = -diff;
        mag       = diff[COORD_W] ? diff_neg[COORD_W-1:0] : diff[COORD_W-1:0];
        sq_next   = SQ_W'(mag) * SQ_W'(mag);
        wr_hit    = wr.en && ({1'b0, wr.sel} == (SEL_W + 1)'(cell_id))
                    && ((DIM_W + 1)'(wr.dim) < (DIM_W + 1)'(MAX_DIMS));
    end

    // stage b: saturating accumulate and running minimum
    always_comb
    begin
        sum_wide = {1'b0, sum_reg} + (DIST_W + 1)'(sq_reg);
        sum_sat  = sum_wide[DIST_W] ? DIST_MAX : sum_wide[DIST_W-1:0];
        active   = (a_tok_reg.remain != '0);
        take     = active && a_tok_reg.last
                   && ((a_tok_reg.pos == '0) || (sum_sat < a_tok_reg.best_dist));
        tok_next = a_tok_reg;
        tok_next.pos = a_tok_reg.pos + 1'b1;
        if (active)
        begin
            tok_next.remain = a_tok_reg.remain - 1'b1;
        end
        if (take)
        begin
            tok_next.best_idx  = a_tok_reg.pos;
            tok_next.best_dist = sum_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_tok_reg <= '0;
            b_tok_reg <= '0;
            sum_reg   <= '0;
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                coord_reg[d] <= '0;
            end
        end
        else
        begin
            a_tok_reg <= tok_in;
            b_tok_reg <= tok_next;
            // end of a point clears every sum, active or not
            if (a_tok_reg.valid)
            begin
                if (a_tok_reg.last)
                    sum_reg <= '0;
                else if (active)
                    sum_reg <= sum_sat;
            end
            if (wr_hit)
            begin
                coord_reg[wr.dim[DIDX_W-1:0]] <= wr.value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= sq_next;
    end

    assign tok_out = b_tok_reg;

endmodule

[src/nearest_center_assign.sv]
`timescale 1ns / 1ps
// Nearest center assignment: center coordinates are loaded one per transaction and do not
// stall the request channel, nor do point coordinates beyond the active dims. A point
// coordinate walks a chain of MAX_CENTERS cells, two registers per cell (square, then
// accumulate and compare), and holds the request channel until it has left the chain. A
// point's last coordinate holds it longer, while its result moves into the output register,
// and longer still while an earlier result waits there unread; once in the output register
// a result may wait while the next coordinates are taken. Ties go to the lowest center
// index. Depends on nca_pkg, nca_if, nca_cell.

module nearest_center_assign
    import nca_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    nca_req_if.sink               req,
    nca_rsp_if.source             rsp,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [ACTC_W-1:0] act_centers_reg;
    logic [ACTD_W-1:0] act_dims_reg;
    logic              busy_reg;
    token_t            head_tok_reg;
    logic              tail_valid_reg;
    logic [CIDX_W-1:0] tail_idx_reg;
    logic [DIST_W-1:0] tail_dist_reg;
    logic              out_valid_reg;
    logic [NEAR_W-1:0] out_idx_reg;
    logic [DIST_W-1:0] out_dist_reg;

    logic [ACTD_W-1:0] nd;
    logic [CNT_W-1:0]  kc;
    logic              accept;
    logic              pt_ok;
    logic              pt_last;
    logic              tail_move;
    center_wr_t        wr;
    token_t            head_tok_next;
    token_t            chain [MAX_CENTERS + 1];

    always_comb
    begin
        if (act_dims_reg == '0)
            nd = ACTD_W'(1);
        else if (act_dims_reg > ACTD_W'(MAX_DIMS))
            nd = ACTD_W'(MAX_DIMS);
        else
            nd = act_dims_reg;

        if (act_centers_reg == '0)
            kc = CNT_W'(1);
        else if ({1'b0, act_centers_reg} > (ACTC_W + 1)'(MAX_CENTERS))
            kc = CNT_W'(MAX_CENTERS);
        else
            kc = CNT_W'(act_centers_reg);

        accept  = req.valid && req.ready;
        pt_ok   = (req.op == OP_POINT) && ({1'b0, req.dim_index} < nd);
        pt_last = ({1'b0, req.dim_index} == (nd - 1'b1));

        wr.en    = accept && (req.op == OP_CENTER);
        wr.sel   = req.center_sel;
        wr.dim   = req.dim_index;
        wr.value = req.coord_value;

        head_tok_next           = '0;
        head_tok_next.valid     = accept && pt_ok;
        head_tok_next.last      = pt_last;
        head_tok_next.dim       = req.dim_index;
        head_tok_next.value     = req.coord_value;
        head_tok_next.remain    = kc;

        tail_move = tail_valid_reg && (!out_valid_reg || rsp.ready);
    end

    assign chain[0] = head_tok_reg;

    for (genvar i = 0; i < MAX_CENTERS; i++)
    begin : g_cell
        nca_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cell_id (CIDX_W'(i)),
            .wr      (wr),
            .tok_in  (chain[i]),
            .tok_out (chain[i + 1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_centers_reg <= ACTC_W'(8);
            act_dims_reg    <= ACTD_W'(16);
            busy_reg        <= 1'b0;
            head_tok_reg    <= '0;
            tail_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_ACTIVE_CENTERS: act_centers_reg <= cfg_data[ACTC_W-1:0];
                    REG_ACTIVE_DIMS:    act_dims_reg    <= cfg_data[ACTD_W-1:0];
                    default:            ;
                endcase
            end

            head_tok_reg <= head_tok_next;

            if (head_tok_next.valid)
                busy_reg <= 1'b1;
            else if ((chain[MAX_CENTERS].valid && !chain[MAX_CENTERS].last) || tail_move)
                busy_reg <= 1'b0;

            if (chain[MAX_CENTERS].valid && chain[MAX_CENTERS].last)
                tail_valid_reg <= 1'b1;
            else if (tail_move)
                tail_valid_reg <= 1'b0;

            if (tail_move)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chain[MAX_CENTERS].valid && chain[MAX_CENTERS].last)
        begin
            tail_idx_reg  <= chain[MAX_CENTERS].best_idx;
            tail_dist_reg <= chain[MAX_CENTERS].best_dist;
        end
        if (tail_move)
        begin
            out_idx_reg  <= NEAR_W'(tail_idx_reg);
            out_dist_reg <= tail_dist_reg;
        end
    end

    assign req.ready            = !busy_reg;
    assign rsp.valid            = out_valid_reg;
    assign rsp.nearest          = out_idx_reg;
    assign rsp.nearest_distance = out_dist_reg;

endmodule

[src/nca_checker.sv]
`timescale 1ns / 1ps
// port-level checks on nearest_center_assign, attached by bind
// depends on nca_pkg and nearest_center_assign

module nca_checker
    import nca_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              req_op,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [DIST_W-1:0] rsp_dist
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result transaction dropped before taken");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_dist))
        else $error("stalled result distance changed");

    // a center load never blocks the next transaction
    a_center_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_op == OP_CENTER) |=> req_ready)
        else $error("center load blocked the request channel");

    // a new result only comes out of a point coordinate in flight
    a_rsp_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("result appeared with no point in flight");

endmodule

bind nearest_center_assign nca_checker u_nca_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_op    (req.op),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_dist  (rsp.nearest_distance)
);
